// File: rtl/pbc_pkg.sv
// ----------------------------------------------------------------------------
// pbc_pkg
// shared types and constants for the pinned buffer cache core
// ----------------------------------------------------------------------------
package pbc_pkg;

    localparam int NUM_FRAMES = 16;
    localparam int BLOCK_BITS = 24;
    localparam int PIN_BITS   = 8;
    localparam int SLOT_BITS  = $clog2(NUM_FRAMES);
    localparam int CNT_BITS   = $clog2(NUM_FRAMES + 1);
    localparam int STAMP_BITS = 16;
    localparam int LIMIT_BITS = 5;

    typedef enum logic [2:0] {
        REQ_PIN       = 3'd0,
        REQ_UNPIN     = 3'd1,
        REQ_DIRTY     = 3'd2,
        REQ_FLUSH     = 3'd3,
        REQ_FLUSH_ALL = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_MISS       = 3'd1,
        ST_NO_FRAME   = 3'd2,
        ST_ABSENT     = 3'd3,
        ST_NOT_PINNED = 3'd4,
        ST_PIN_LIMIT  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_OUT,
        S_WALK,
        S_WOUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;    // latch request, clear scan state
        logic scan_step;  // look at frame under scan index
        logic exec;       // apply request using scan results, load result
        logic walk_step;  // flush-all: test frame under index, emit if dirty
        logic walk_none;  // flush-all found nothing: load empty result
    } pbc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic is_flush_all;
        logic walk_hit;
        logic walk_last;
        logic walk_any;
        logic walk_later; // a dirty frame lies past the walk index
    } pbc_sts_t;

endpackage

// File: rtl/pbc_datapath.sv
// ----------------------------------------------------------------------------
// pbc_datapath
// frame store, sequential lookup and victim scan, result register
// ----------------------------------------------------------------------------
module pbc_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pbc_pkg::pbc_cmd_t               cmd,
    output pbc_pkg::pbc_sts_t               sts,
    input  logic [2:0]                      req_type,
    input  logic [pbc_pkg::BLOCK_BITS-1:0]  disk_block,
    input  logic [pbc_pkg::LIMIT_BITS-1:0]  frame_limit,
    output logic [2:0]                      status,
    output logic [3:0]                      slot,
    output logic                            write_valid,
    output logic [pbc_pkg::BLOCK_BITS-1:0]  write_block,
    output logic [3:0]                      write_slot,
    output logic                            read_valid,
    output logic                            last
);
    localparam int N  = pbc_pkg::NUM_FRAMES;
    localparam int SB = pbc_pkg::SLOT_BITS;
    localparam int CB = pbc_pkg::CNT_BITS;
    localparam int BB = pbc_pkg::BLOCK_BITS;
    localparam int PB = pbc_pkg::PIN_BITS;
    localparam int TB = pbc_pkg::STAMP_BITS;

    logic [N-1:0]  valid_reg, dirty_reg;
    logic [BB-1:0] tag_reg   [N];
    logic [PB-1:0] pin_reg   [N];
    logic [TB-1:0] stamp_reg [N];
    logic [CB-1:0] in_use_reg;
    logic [TB-1:0] counter_reg;

    logic [2:0]    req_reg;
    logic [BB-1:0] blk_reg;
    logic [CB-1:0] idx_reg;
    logic          hit_reg, vic_reg;
    logic [SB-1:0] hit_slot_reg, vic_slot_reg;
    logic [TB-1:0] vic_age_reg;
    logic          any_reg;

    logic [2:0]    status_reg;
    logic [3:0]    slot_reg, wslot_reg;
    logic          wv_reg, rv_reg, last_reg;
    logic [BB-1:0] wblk_reg;

    logic [SB-1:0] idx;
    logic [TB-1:0] age;
    logic [CB-1:0] lim;
    logic [SB-1:0] hs, vs;
    logic [PB-1:0] pmax;
    logic [N-1:0]  later_mask;

    assign idx  = idx_reg[SB-1:0];
    assign age  = counter_reg - stamp_reg[idx];
    assign hs   = hit_slot_reg;
    assign vs   = vic_slot_reg;
    assign pmax = '1;

    always_comb
    begin
        if (frame_limit == '0)
            lim = CB'(1);
        else if (32'(frame_limit) > N)
            lim = CB'(N);
        else
            lim = CB'(frame_limit);
    end

    // frames above the walk index
    always_comb
    begin
        for (int i = 0; i < N; i++)
            later_mask[i] = (i > int'(idx));
    end

    assign sts.scan_done    = (idx_reg == CB'(N-1));
    assign sts.is_flush_all = (req_reg == pbc_pkg::REQ_FLUSH_ALL);
    assign sts.walk_hit     = valid_reg[idx] & dirty_reg[idx];
    assign sts.walk_last    = (idx_reg == CB'(N-1));
    assign sts.walk_any     = any_reg;
    assign sts.walk_later   = |(valid_reg & dirty_reg & later_mask);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            dirty_reg    <= '0;
            in_use_reg   <= '0;
            counter_reg  <= '0;
            req_reg      <= '0;
            blk_reg      <= '0;
            idx_reg      <= '0;
            hit_reg      <= 1'b0;
            vic_reg      <= 1'b0;
            hit_slot_reg <= '0;
            vic_slot_reg <= '0;
            vic_age_reg  <= '0;
            any_reg      <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                pin_reg[i]   <= '0;
                stamp_reg[i] <= '0;
            end
        end
        else if (cmd.capture)
        begin
            req_reg <= req_type;
            blk_reg <= disk_block;
            idx_reg <= '0;
            hit_reg <= 1'b0;
            vic_reg <= 1'b0;
            any_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (valid_reg[idx] && tag_reg[idx] == blk_reg && !hit_reg)
            begin
                hit_reg      <= 1'b1;
                hit_slot_reg <= idx;
            end
            if (valid_reg[idx] && pin_reg[idx] == '0 && (!vic_reg || age > vic_age_reg))
            begin
                vic_reg      <= 1'b1;
                vic_slot_reg <= idx;
                vic_age_reg  <= age;
            end
            if (!sts.scan_done)
                idx_reg <= idx_reg + CB'(1);
        end
        else if (cmd.walk_step)
        begin
            if (sts.walk_hit)
            begin
                dirty_reg[idx] <= 1'b0;
                any_reg        <= 1'b1;
            end
            if (!sts.walk_last)
                idx_reg <= idx_reg + CB'(1);
        end
        else if (cmd.exec)
        begin
            unique case (req_reg)
                pbc_pkg::REQ_PIN:
                begin
                    if (hit_reg)
                    begin
                        if (pin_reg[hs] != pmax)
                            pin_reg[hs] <= pin_reg[hs] + PB'(1);
                    end
                    else if (in_use_reg < lim)
                    begin
                        in_use_reg <= in_use_reg + CB'(1);
                        valid_reg[in_use_reg[SB-1:0]] <= 1'b1;
                        tag_reg[in_use_reg[SB-1:0]]   <= blk_reg;
                        pin_reg[in_use_reg[SB-1:0]]   <= PB'(1);
                        dirty_reg[in_use_reg[SB-1:0]] <= 1'b0;
                    end
                    else if (vic_reg)
                    begin
                        tag_reg[vs]   <= blk_reg;
                        pin_reg[vs]   <= PB'(1);
                        dirty_reg[vs] <= 1'b0;
                    end
                end
                pbc_pkg::REQ_UNPIN:
                begin
                    if (hit_reg && pin_reg[hs] != '0)
                    begin
                        pin_reg[hs] <= pin_reg[hs] - PB'(1);
                        if (pin_reg[hs] == PB'(1))
                        begin
                            stamp_reg[hs] <= counter_reg;
                            counter_reg   <= counter_reg + TB'(1);
                        end
                    end
                end
                pbc_pkg::REQ_DIRTY:
                begin
                    if (hit_reg)
                        dirty_reg[hs] <= 1'b1;
                end
                pbc_pkg::REQ_FLUSH:
                begin
                    if (hit_reg)
                        dirty_reg[hs] <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.walk_step && sts.walk_hit)
        begin
            status_reg <= pbc_pkg::ST_OK;
            slot_reg   <= 4'(idx);
            wv_reg     <= 1'b1;
            wblk_reg   <= tag_reg[idx];
            wslot_reg  <= 4'(idx);
            rv_reg     <= 1'b0;
            last_reg   <= !sts.walk_later;
        end
        else if (cmd.walk_none)
        begin
            status_reg <= pbc_pkg::ST_OK;
            slot_reg   <= '0;
            wv_reg     <= 1'b0;
            wblk_reg   <= '0;
            wslot_reg  <= '0;
            rv_reg     <= 1'b0;
            last_reg   <= 1'b1;
        end
        else if (cmd.exec)
        begin
            status_reg <= pbc_pkg::ST_ABSENT;
            slot_reg   <= '0;
            wv_reg     <= 1'b0;
            wblk_reg   <= '0;
            wslot_reg  <= '0;
            rv_reg     <= 1'b0;
            last_reg   <= 1'b1;
            unique case (req_reg)
                pbc_pkg::REQ_PIN:
                begin
                    if (hit_reg)
                    begin
                        status_reg <= (pin_reg[hs] == pmax) ? pbc_pkg::ST_PIN_LIMIT
                                                            : pbc_pkg::ST_OK;
                        slot_reg   <= 4'(hs);
                    end
                    else if (in_use_reg < lim)
                    begin
                        status_reg <= pbc_pkg::ST_MISS;
                        slot_reg   <= 4'(in_use_reg[SB-1:0]);
                        rv_reg     <= 1'b1;
                    end
                    else if (vic_reg)
                    begin
                        status_reg <= pbc_pkg::ST_MISS;
                        slot_reg   <= 4'(vs);
                        rv_reg     <= 1'b1;
                        if (dirty_reg[vs])
                        begin
                            wv_reg    <= 1'b1;
                            wblk_reg  <= tag_reg[vs];
                            wslot_reg <= 4'(vs);
                        end
                    end
                    else
                        status_reg <= pbc_pkg::ST_NO_FRAME;
                end
                pbc_pkg::REQ_UNPIN:
                begin
                    if (hit_reg)
                    begin
                        status_reg <= (pin_reg[hs] == '0) ? pbc_pkg::ST_NOT_PINNED
                                                          : pbc_pkg::ST_OK;
                        slot_reg   <= 4'(hs);
                    end
                end
                pbc_pkg::REQ_DIRTY:
                begin
                    if (hit_reg)
                    begin
                        status_reg <= pbc_pkg::ST_OK;
                        slot_reg   <= 4'(hs);
                    end
                end
                pbc_pkg::REQ_FLUSH:
                begin
                    if (hit_reg)
                    begin
                        status_reg <= pbc_pkg::ST_OK;
                        slot_reg   <= 4'(hs);
                        if (dirty_reg[hs])
                        begin
                            wv_reg    <= 1'b1;
                            wblk_reg  <= tag_reg[hs];
                            wslot_reg <= 4'(hs);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign status      = status_reg;
    assign slot        = slot_reg;
    assign write_valid = wv_reg;
    assign write_block = wblk_reg;
    assign write_slot  = wslot_reg;
    assign read_valid  = rv_reg;
    // on a walk result, last is set when no dirty frame remains after it
    assign last        = last_reg;
endmodule

// File: rtl/pbc_ctrl.sv
// ----------------------------------------------------------------------------
// pbc_ctrl
// request sequencer: scan, execute, deliver, flush-all walk
// ----------------------------------------------------------------------------
module pbc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output pbc_pkg::pbc_cmd_t  cmd,
    input  pbc_pkg::pbc_sts_t  sts
);
    pbc_pkg::state_t state_reg, state_next;
    logic more_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pbc_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pbc_pkg::S_IDLE:
                if (in_valid)
                    state_next = pbc_pkg::S_SCAN;
            pbc_pkg::S_SCAN:
                if (sts.is_flush_all)
                    state_next = pbc_pkg::S_WALK;
                else if (sts.scan_done)
                    state_next = pbc_pkg::S_EXEC;
            pbc_pkg::S_EXEC:
                state_next = pbc_pkg::S_OUT;
            pbc_pkg::S_OUT:
                if (!out_stall)
                    state_next = pbc_pkg::S_IDLE;
            pbc_pkg::S_WALK:
                if (sts.walk_hit)
                    state_next = pbc_pkg::S_WOUT;
                else if (sts.walk_last)
                    state_next = sts.walk_any ? pbc_pkg::S_IDLE : pbc_pkg::S_OUT;
            pbc_pkg::S_WOUT:
                if (!out_stall)
                    state_next = more_reg ? pbc_pkg::S_WALK : pbc_pkg::S_IDLE;
            default:
                state_next = pbc_pkg::S_IDLE;
        endcase
    end

    // the walk resumes after a write-back only while a later dirty frame exists
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            more_reg <= 1'b0;
        else if (state_reg == pbc_pkg::S_WALK && sts.walk_hit)
            more_reg <= sts.walk_later;
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            pbc_pkg::S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            pbc_pkg::S_SCAN:
                cmd.scan_step = !sts.is_flush_all;
            pbc_pkg::S_EXEC:
                cmd.exec = 1'b1;
            pbc_pkg::S_OUT:
                out_valid = 1'b1;
            pbc_pkg::S_WALK:
            begin
                cmd.walk_step = 1'b1;
                cmd.walk_none = sts.walk_last && !sts.walk_hit && !sts.walk_any;
            end
            pbc_pkg::S_WOUT:
                out_valid = 1'b1;
            default:
            begin
            end
        endcase
    end
endmodule

// File: rtl/pinned_buffer_cache_lru_core.sv
// ----------------------------------------------------------------------------
// pinned_buffer_cache_lru_core
// buffer pool frame manager with pin counts and least-recently-released eviction
// ----------------------------------------------------------------------------
// One request at a time. A pin, unpin, mark dirty or flush request scans all
// sixteen frames one per cycle (tag match and oldest unpinned victim), then
// applies the update and presents one result, which output stall can hold
// before the next request is accepted. Flush-all walks the frames one per
// cycle and stops at each dirty one to present a write-back transfer; the walk
// ends at the last dirty frame. last on a walk result is found by looking at
// the dirty frames past the current one. The result register holds a transfer
// until the consumer drops stall. frame_limit is written through the cfg
// channel; the user is to write it only while idle, which the block itself
// does not enforce.
module pinned_buffer_cache_lru_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [2:0]                      req_type,
    input  logic [pbc_pkg::BLOCK_BITS-1:0]  disk_block,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      status,
    output logic [3:0]                      slot,
    output logic                            write_valid,
    output logic [pbc_pkg::BLOCK_BITS-1:0]  write_block,
    output logic [3:0]                      write_slot,
    output logic                            read_valid,
    output logic                            last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pbc_pkg::LIMIT_BITS-1:0]  cfg_data
);
    pbc_pkg::pbc_cmd_t cmd;
    pbc_pkg::pbc_sts_t sts;
    logic [pbc_pkg::LIMIT_BITS-1:0] limit_reg;

    // config register, always writable
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= pbc_pkg::LIMIT_BITS'(pbc_pkg::NUM_FRAMES);
        else if (cfg_valid)
            limit_reg <= cfg_data;
    end

    pbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    pbc_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req_type),
        .disk_block  (disk_block),
        .frame_limit (limit_reg),
        .status      (status),
        .slot        (slot),
        .write_valid (write_valid),
        .write_block (write_block),
        .write_slot  (write_slot),
        .read_valid  (read_valid),
        .last        (last)
    );
endmodule

// File: rtl/pbc_checker.sv
// ----------------------------------------------------------------------------
// pbc_checker
// port-level checks for the buffer cache core
// ----------------------------------------------------------------------------
module pbc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] status,
    input logic       read_valid,
    input logic       write_valid
);
    // a read command only comes with a miss
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_valid |-> status == pbc_pkg::ST_MISS)
        else $error("read without miss");

    // a write-back only comes with an ok or a miss
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_valid |-> status == pbc_pkg::ST_OK || status == pbc_pkg::ST_MISS)
        else $error("write-back with bad status");

    // no input taken while a result is shown
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted during output");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("stalled result changed");

    // an accepted request is never answered in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("result too early");
endmodule

bind pinned_buffer_cache_lru_core pbc_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .read_valid  (read_valid),
    .write_valid (write_valid)
);

// File: dv/pinned_buffer_cache_lru_core_tb.sv
// ----------------------------------------------------------------------------
// pinned_buffer_cache_lru_core_tb
// self-checking bench: a scoreboard model of the frame manager predicts every
// result transfer, a clocked driver and monitor move requests and results
// under random valid gaps and output stalls, frame_limit is swept between phases
// ----------------------------------------------------------------------------
module pinned_buffer_cache_lru_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIN_MAX   = (1 << pbc_pkg::PIN_BITS) - 1;
    localparam int MAX_CYC   = 2000000;
    localparam int DRAIN_CYC = 60;

    typedef struct {
        logic [2:0]                     kind;
        logic [pbc_pkg::BLOCK_BITS-1:0] blk;
    } cache_req_t;

    typedef struct {
        logic [2:0]                     status;
        logic [3:0]                     slot;
        logic                           wv;
        logic [pbc_pkg::BLOCK_BITS-1:0] wb;
        logic [3:0]                     ws;
        logic                           rv;
        logic                           last;
    } cache_rsp_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [2:0]                      req_type;
    logic [pbc_pkg::BLOCK_BITS-1:0]  disk_block;
    logic                            out_valid;
    logic                            out_stall;
    logic [2:0]                      status;
    logic [3:0]                      slot;
    logic                            write_valid;
    logic [pbc_pkg::BLOCK_BITS-1:0]  write_block;
    logic [3:0]                      write_slot;
    logic                            read_valid;
    logic                            last;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [pbc_pkg::LIMIT_BITS-1:0]  cfg_data;

    pinned_buffer_cache_lru_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .disk_block  (disk_block),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .slot        (slot),
        .write_valid (write_valid),
        .write_block (write_block),
        .write_slot  (write_slot),
        .read_valid  (read_valid),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    // clock, 4 ns period
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow copy of the frame table
    // ------------------------------------------------------------------
    logic [4:0]                     m_limit;
    logic                           m_valid [pbc_pkg::NUM_FRAMES];
    logic [pbc_pkg::BLOCK_BITS-1:0] m_tag   [pbc_pkg::NUM_FRAMES];
    logic [pbc_pkg::PIN_BITS-1:0]   m_pins  [pbc_pkg::NUM_FRAMES];
    logic                           m_dirty [pbc_pkg::NUM_FRAMES];
    logic [15:0]                    m_rel   [pbc_pkg::NUM_FRAMES];
    int                             m_used;
    logic [15:0]                    m_stamp;

    cache_req_t pending_reqs[$];
    cache_rsp_t expected_rsps[$];

    int  errors;
    int  rsp_seen;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  sent_cnt;
    int  hit_cnt, miss_cnt, evict_wb_cnt, flush_all_multi;
    longint cycles;

    function automatic cache_rsp_t mk_rsp(logic [2:0] st, int s, logic wv,
                                          logic [pbc_pkg::BLOCK_BITS-1:0] wb, logic rv,
                                          logic lst);
        cache_rsp_t r;
        r.status = st;
        r.slot   = s[3:0];
        r.wv     = wv;
        r.wb     = wv ? wb : '0;
        r.ws     = wv ? s[3:0] : 4'd0;
        r.rv     = rv;
        r.last   = lst;
        return r;
    endfunction

    function automatic int find_frame(logic [pbc_pkg::BLOCK_BITS-1:0] b);
        for (int i = 0; i < pbc_pkg::NUM_FRAMES; i++)
            if (m_valid[i] && m_tag[i] == b)
                return i;
        return -1;
    endfunction

    // oldest released frame with no pins, lowest index wins a tie
    function automatic int pick_victim();
        int          best;
        logic [15:0] best_age;
        logic [15:0] age;
        best = -1;
        best_age = '0;
        for (int i = 0; i < pbc_pkg::NUM_FRAMES; i++)
            if (m_valid[i] && m_pins[i] == 0)
            begin
                age = m_stamp - m_rel[i];
                if (best < 0 || age > best_age)
                begin
                    best = i;
                    best_age = age;
                end
            end
        return best;
    endfunction

    // apply one request to the shadow table and queue what it should emit
    task automatic predict_cache(cache_req_t q);
        int s;
        int lim;
        int n;
        lim = (m_limit < 1) ? 1 : ((m_limit > pbc_pkg::NUM_FRAMES) ? pbc_pkg::NUM_FRAMES
                                                                    : int'(m_limit));
        s = find_frame(q.blk);
        case (q.kind)
            pbc_pkg::REQ_PIN:
            begin
                if (s >= 0)
                begin
                    if (m_pins[s] == PIN_MAX)
                        expected_rsps.push_back(mk_rsp(pbc_pkg::ST_PIN_LIMIT, s, 0, 0, 0, 1));
                    else
                    begin
                        m_pins[s]++;
                        hit_cnt++;
                        expected_rsps.push_back(mk_rsp(pbc_pkg::ST_OK, s, 0, 0, 0, 1));
                    end
                end
                else if (m_used < lim)
                begin
                    s = m_used;
                    m_used++;
                    m_valid[s] = 1'b1;
                    m_tag[s]   = q.blk;
                    m_pins[s]  = 1;
                    m_dirty[s] = 1'b0;
                    miss_cnt++;
                    expected_rsps.push_back(mk_rsp(pbc_pkg::ST_MISS, s, 0, 0, 1, 1));
                end
                else
                begin
                    s = pick_victim();
                    if (s < 0)
                        expected_rsps.push_back(mk_rsp(pbc_pkg::ST_NO_FRAME, 0, 0, 0, 0, 1));
                    else
                    begin
                        if (m_dirty[s])
                            evict_wb_cnt++;
                        expected_rsps.push_back(mk_rsp(pbc_pkg::ST_MISS, s, m_dirty[s],
                                                       m_tag[s], 1, 1));
                        m_tag[s]   = q.blk;
                        m_pins[s]  = 1;
                        m_dirty[s] = 1'b0;
                        miss_cnt++;
                    end
                end
            end
            pbc_pkg::REQ_UNPIN:
            begin
                if (s < 0)
                    expected_rsps.push_back(mk_rsp(pbc_pkg::ST_ABSENT, 0, 0, 0, 0, 1));
                else if (m_pins[s] == 0)
                    expected_rsps.push_back(mk_rsp(pbc_pkg::ST_NOT_PINNED, s, 0, 0, 0, 1));
                else
                begin
                    m_pins[s]--;
                    if (m_pins[s] == 0)
                    begin
                        m_rel[s] = m_stamp;
                        m_stamp++;
                    end
                    expected_rsps.push_back(mk_rsp(pbc_pkg::ST_OK, s, 0, 0, 0, 1));
                end
            end
            pbc_pkg::REQ_DIRTY:
            begin
                if (s < 0)
                    expected_rsps.push_back(mk_rsp(pbc_pkg::ST_ABSENT, 0, 0, 0, 0, 1));
                else
                begin
                    m_dirty[s] = 1'b1;
                    expected_rsps.push_back(mk_rsp(pbc_pkg::ST_OK, s, 0, 0, 0, 1));
                end
            end
            pbc_pkg::REQ_FLUSH:
            begin
                if (s < 0)
                    expected_rsps.push_back(mk_rsp(pbc_pkg::ST_ABSENT, 0, 0, 0, 0, 1));
                else
                begin
                    expected_rsps.push_back(mk_rsp(pbc_pkg::ST_OK, s, m_dirty[s], m_tag[s],
                                                   0, 1));
                    m_dirty[s] = 1'b0;
                end
            end
            pbc_pkg::REQ_FLUSH_ALL:
            begin
                n = 0;
                for (int i = 0; i < pbc_pkg::NUM_FRAMES; i++)
                    if (m_valid[i] && m_dirty[i])
                    begin
                        m_dirty[i] = 1'b0;
                        expected_rsps.push_back(mk_rsp(pbc_pkg::ST_OK, i, 1, m_tag[i], 0, 0));
                        n++;
                    end
                if (n == 0)
                    expected_rsps.push_back(mk_rsp(pbc_pkg::ST_OK, 0, 0, 0, 0, 1));
                else
                    expected_rsps[$].last = 1'b1;
                if (n > 1)
                    flush_all_multi++;
            end
            default:
                expected_rsps.push_back(mk_rsp(pbc_pkg::ST_ABSENT, 0, 0, 0, 0, 1));
        endcase
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 rsp_seen, what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // driver: one request transfer at a time from pending_reqs
    // ------------------------------------------------------------------
    logic hold_off;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            req_type   <= '0;
            disk_block <= '0;
            sent_cnt   <= 0;
        end
        else
        begin
            // a transfer completed at this edge: predict it and drop it
            if (in_valid && !in_stall)
            begin
                predict_cache(pending_reqs.pop_front());
                sent_cnt <= sent_cnt + 1;
            end
            // keep a stalled payload steady, otherwise pick the next one
            if (!(in_valid && in_stall))
            begin
                if (pending_reqs.size() > 0 && !hold_off &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid   <= 1'b1;
                    req_type   <= pending_reqs[0].kind;
                    disk_block <= pending_reqs[0].blk;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: compare each result transfer with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rsp_seen  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("unexpected result transfer, status %0d slot %0d",
                             status, slot);
                    errors++;
                end
                else
                begin
                    cache_rsp_t e;
                    e = expected_rsps.pop_front();
                    if (status !== e.status)      report_mismatch("status", status, e.status);
                    if (slot !== e.slot)          report_mismatch("slot", slot, e.slot);
                    if (write_valid !== e.wv)     report_mismatch("write_valid", write_valid, e.wv);
                    if (write_block !== e.wb)     report_mismatch("write_block", write_block, e.wb);
                    if (write_slot !== e.ws)      report_mismatch("write_slot", write_slot, e.ws);
                    if (read_valid !== e.rv)      report_mismatch("read_valid", read_valid, e.rv);
                    if (last !== e.last)          report_mismatch("last", last, e.last);
                end
                rsp_seen <= rsp_seen + 1;
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC)
        begin
            $display("timeout with %0d requests and %0d results outstanding",
                     pending_reqs.size(), expected_rsps.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_req(logic [2:0] k, logic [pbc_pkg::BLOCK_BITS-1:0] b);
        cache_req_t q;
        q.kind = k;
        q.blk  = b;
        pending_reqs.push_back(q);
    endfunction

    // small block pool so hits, evictions and pin churn happen often
    function automatic logic [pbc_pkg::BLOCK_BITS-1:0] pool_blk(int span);
        logic [pbc_pkg::BLOCK_BITS-1:0] b;
        b = pbc_pkg::BLOCK_BITS'($urandom_range(span - 1));
        // spread pool members across high bits too
        if (b[0])
            b = b ^ 24'hA5_0000;
        if (b[1])
            b = b | 24'h80_0000;
        return b;
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
            @(posedge clk);
        // let the core settle back to idle before the next phase
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_limit(logic [4:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        m_limit = v;
    endtask

    // random mix: mostly pin/unpin sessions, some dirty and flush traffic
    task automatic add_random(int n, int span);
        int r;
        logic [pbc_pkg::BLOCK_BITS-1:0] b;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            b = pool_blk(span);
            if (r < 35)
                add_req(pbc_pkg::REQ_PIN, b);
            else if (r < 65)
                add_req(pbc_pkg::REQ_UNPIN, b);
            else if (r < 78)
                add_req(pbc_pkg::REQ_DIRTY, b);
            else if (r < 87)
                add_req(pbc_pkg::REQ_FLUSH, b);
            else if (r < 93)
                add_req(pbc_pkg::REQ_FLUSH_ALL, pbc_pkg::BLOCK_BITS'($urandom()));
            else if (r < 97)
                add_req(3'($urandom_range(7)), pbc_pkg::BLOCK_BITS'($urandom()));
            else
                add_req(pbc_pkg::REQ_PIN, pbc_pkg::BLOCK_BITS'($urandom()));
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        errors = 0;
        cycles = 0;
        hold_off = 1'b0;
        hit_cnt = 0;
        miss_cnt = 0;
        evict_wb_cnt = 0;
        flush_all_multi = 0;
        send_idle_pct = 16;
        recv_idle_pct = 81;
        cfg_valid = 1'b0;
        cfg_data = '0;
        m_limit = 5'd16;
        m_used = 0;
        m_stamp = '0;
        for (int i = 0; i < pbc_pkg::NUM_FRAMES; i++)
        begin
            m_valid[i] = 1'b0;
            m_tag[i]   = '0;
            m_pins[i]  = '0;
            m_dirty[i] = 1'b0;
            m_rel[i]   = '0;
        end
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: limit 2 exercises allocation, eviction and every status but the pin limit
        write_limit(5'd2);
        add_req(pbc_pkg::REQ_UNPIN, 24'h000000);     // unpin of absent block
        add_req(pbc_pkg::REQ_DIRTY, 24'hFFFFFF);     // mark dirty of absent block
        add_req(pbc_pkg::REQ_FLUSH, 24'h123456);     // flush of absent block
        add_req(pbc_pkg::REQ_FLUSH_ALL, 24'h000000); // nothing dirty yet
        add_req(pbc_pkg::REQ_PIN, 24'h000000);       // miss, slot 0
        add_req(pbc_pkg::REQ_PIN, 24'hFFFFFF);       // miss, slot 1
        add_req(pbc_pkg::REQ_PIN, 24'h000000);       // hit
        add_req(pbc_pkg::REQ_PIN, 24'h555555);       // everything pinned
        add_req(pbc_pkg::REQ_DIRTY, 24'hFFFFFF);
        add_req(pbc_pkg::REQ_FLUSH, 24'hFFFFFF);     // write-back, dirty cleared
        add_req(pbc_pkg::REQ_FLUSH, 24'hFFFFFF);     // clean flush
        add_req(pbc_pkg::REQ_DIRTY, 24'h000000);
        add_req(pbc_pkg::REQ_DIRTY, 24'hFFFFFF);
        add_req(pbc_pkg::REQ_UNPIN, 24'hFFFFFF);     // released first, oldest
        add_req(pbc_pkg::REQ_UNPIN, 24'hFFFFFF);     // unpin of unpinned frame
        add_req(pbc_pkg::REQ_UNPIN, 24'h000000);
        add_req(pbc_pkg::REQ_UNPIN, 24'h000000);     // one pin left from the hit
        add_req(pbc_pkg::REQ_PIN, 24'hAAAAAA);       // evicts dirty slot 1
        add_req(pbc_pkg::REQ_FLUSH_ALL, 24'hFFFFFF); // one dirty frame
        add_req(3'd5, 24'h000001);                   // undefined request codes
        add_req(3'd7, 24'hFFFFFF);
        wait_idle();

        // pin count saturation on one frame, which stays fully pinned after
        write_limit(5'd16);
        for (int i = 0; i < PIN_MAX + 1; i++)
            add_req(pbc_pkg::REQ_PIN, 24'hC0FFEE);
        wait_idle();

        // phase 1: sender rarely idles, receiver mostly stalls, limit 16
        add_random(20, 24);
        for (int i = 0; i < pbc_pkg::NUM_FRAMES; i++)
            add_req(pbc_pkg::REQ_DIRTY, pool_blk(24));
        add_req(pbc_pkg::REQ_FLUSH_ALL, '0);
        add_random(20, 24);
        // sender pauses until every result is back
        hold_off = 1'b1;
        while (expected_rsps.size() > 0 || in_valid)
            @(posedge clk);
        hold_off = 1'b0;
        add_random(10, 24);
        wait_idle();

        // phase 2: roles swapped, limit 0 acts as one frame
        send_idle_pct = 81;
        recv_idle_pct = 16;
        write_limit(5'd0);
        add_random(25, 8);
        wait_idle();
        write_limit(5'd31);
        add_random(20, 40);
        wait_idle();

        // phase 3: no idling, tight limit forces heavy replacement
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit(5'd5);
        add_random(25, 30);
        wait_idle();

        $display("requests %0d, results %0d: hits %0d, misses %0d, dirty evictions %0d,",
                 sent_cnt, rsp_seen, hit_cnt, miss_cnt, evict_wb_cnt);
        $display("multi-frame flush-alls %0d, frame limits 2 16 0 31 5", flush_all_multi);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: filelist.f
rtl/pbc_pkg.sv
rtl/pbc_datapath.sv
rtl/pbc_ctrl.sv
rtl/pinned_buffer_cache_lru_core.sv
rtl/pbc_checker.sv
dv/pinned_buffer_cache_lru_core_tb.sv
